>>> rtl/rmq_pkg.sv
package rmq_pkg;

    localparam int ENTRIES  = 1024;
    localparam int IDX_W    = 10;
    localparam int HEIGHT_W = 31;
    // heap-ordered tree: root at 1, leaf i at ENTRIES + i
    localparam int TREE_W   = IDX_W + 1;
    localparam int TREE_D   = 2 * ENTRIES;
    // query bounds run up to 2 * ENTRIES, one bit wider than a node address
    localparam int PTR_W    = IDX_W + 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [IDX_W-1:0]    index_low;
        logic [IDX_W-1:0]    index_high;
        logic [HEIGHT_W-1:0] height;
    } rmq_cmd_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] max_height;
        logic [IDX_W-1:0]    max_index;
        logic                range_error;
    } rmq_result_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] best;
        logic [IDX_W-1:0]    where;
    } rmq_node_t;

    localparam int NODE_W = $bits(rmq_node_t);

    // left operand wins ties, which keeps the leftmost position
    function automatic rmq_node_t rmq_pick(rmq_node_t lft, rmq_node_t rgt);
        rmq_pick = (lft.best >= rgt.best) ? lft : rgt;
    endfunction

endpackage

>>> rtl/rmq_ram.sv
module rmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/range_max_with_index_query_top.sv
// write item: leaf written on acceptance, then busy for one read-modify-write per level up to the root
// query item: a left-bound step and a right-bound step per tree level, then a merge step before the result strobe
// a bad query range gives its result in the cycle after acceptance
// one item at a time; the single read port of the node memory sets the pace
// rst_n clears control state only; node memory is undefined until written
module range_max_with_index_query_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rmq_pkg::rmq_cmd_t    cmd,
    output logic                 busy,
    output logic                 done,
    output rmq_pkg::rmq_result_t result
);

    import rmq_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;  // walk from leaf to root
    localparam logic [2:0] ST_QL    = 3'd2;  // left bound of one level
    localparam logic [2:0] ST_QR    = 3'd3;  // right bound of one level
    localparam logic [2:0] ST_QDONE = 3'd4;  // merge both sides, emit

    localparam logic SIDE_L = 1'b0;
    localparam logic SIDE_R = 1'b1;

    logic [2:0]  state_reg, state_next;

    // update walk
    logic [TREE_W-1:0] node_reg, node_next;
    rmq_node_t         cur_reg, cur_next;

    // query bounds, half-open [l, r) in leaf coordinates
    logic [PTR_W-1:0] l_reg, l_next;
    logic [PTR_W-1:0] r_reg, r_next;

    // left and right partial maxima
    rmq_node_t acc_l_reg, acc_l_next;
    rmq_node_t acc_r_reg, acc_r_next;
    logic      acc_l_vld_reg, acc_l_vld_next;
    logic      acc_r_vld_reg, acc_r_vld_next;

    // one node read in flight, lands next cycle
    logic pend_reg, pend_next;
    logic pend_side_reg, pend_side_next;

    logic        done_reg, done_next;
    rmq_result_t result_reg, result_next;

    // node memory ports
    logic              wr_en;
    logic [TREE_W-1:0] wr_addr;
    rmq_node_t         wr_data;
    logic              rd_en;
    logic [TREE_W-1:0] rd_addr;
    logic [NODE_W-1:0] rd_word;
    rmq_node_t         rd_node;

    logic              accept;
    logic              bad_range;
    logic              write_ok;
    logic [TREE_W-1:0] leaf;
    logic [TREE_W-1:0] parent;
    rmq_node_t         merged;
    rmq_node_t         acc_both;

    rmq_ram #(
        .WIDTH (NODE_W),
        .DEPTH (TREE_D)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    assign rd_node = rmq_node_t'(rd_word);

    assign accept    = start && (state_reg == ST_IDLE);
    assign bad_range = (cmd.index_low > cmd.index_high) ||
                       ({1'b0, cmd.index_high} >= (IDX_W+1)'(ENTRIES));
    assign write_ok  = ({1'b0, cmd.index_low} < (IDX_W+1)'(ENTRIES));
    assign leaf      = TREE_W'(cmd.index_low) + TREE_W'(ENTRIES);
    assign parent    = node_reg >> 1;
    // even node is the left child, so the sibling sits on the right
    assign merged    = node_reg[0] ? rmq_pick(rd_node, cur_reg) : rmq_pick(cur_reg, rd_node);
    // left side covers lower positions, so it wins ties
    assign acc_both  = rmq_pick(acc_l_reg, acc_r_reg);

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        acc_l_next     = acc_l_reg;
        acc_r_next     = acc_r_reg;
        acc_l_vld_next = acc_l_vld_reg;
        acc_r_vld_next = acc_r_vld_reg;
        pend_next      = 1'b0;
        pend_side_next = pend_side_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        wr_en          = 1'b0;
        wr_addr        = leaf;
        wr_data        = cur_reg;
        rd_en          = 1'b0;
        rd_addr        = leaf ^ TREE_W'(1);

        // fold in the node read last cycle, keeping left-to-right order
        if (pend_reg)
        begin
            if (pend_side_reg == SIDE_L)
            begin
                acc_l_next     = acc_l_vld_reg ? rmq_pick(acc_l_reg, rd_node) : rd_node;
                acc_l_vld_next = 1'b1;
            end
            else
            begin
                acc_r_next     = acc_r_vld_reg ? rmq_pick(rd_node, acc_r_reg) : rd_node;
                acc_r_vld_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.opcode == OP_WRITE)
                    begin
                        if (write_ok)
                        begin
                            // store the leaf and fetch its sibling together
                            wr_en      = 1'b1;
                            wr_addr    = leaf;
                            wr_data    = '{best: cmd.height, where: cmd.index_low};
                            rd_en      = 1'b1;
                            rd_addr    = leaf ^ TREE_W'(1);
                            node_next  = leaf;
                            cur_next   = '{best: cmd.height, where: cmd.index_low};
                            state_next = ST_UPD;
                        end
                    end
                    else if (bad_range)
                    begin
                        done_next   = 1'b1;
                        result_next = '{max_height: '0, max_index: '0, range_error: 1'b1};
                    end
                    else
                    begin
                        l_next = PTR_W'(cmd.index_low) + PTR_W'(ENTRIES);
                        r_next = PTR_W'(cmd.index_high) + PTR_W'(ENTRIES) + PTR_W'(1);
                        acc_l_vld_next = 1'b0;
                        acc_r_vld_next = 1'b0;
                        state_next     = ST_QL;
                    end
                end
            end

            ST_UPD:
            begin
                // sibling data is here: write the parent, fetch the next sibling
                wr_en     = 1'b1;
                wr_addr   = parent;
                wr_data   = merged;
                cur_next  = merged;
                node_next = parent;
                if (parent == TREE_W'(1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    rd_en   = 1'b1;
                    rd_addr = parent ^ TREE_W'(1);
                end
            end

            ST_QL:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = ST_QDONE;
                end
                else
                begin
                    if (l_reg[0])
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = l_reg[TREE_W-1:0];
                        pend_next      = 1'b1;
                        pend_side_next = SIDE_L;
                        l_next         = l_reg + PTR_W'(1);
                    end
                    state_next = ST_QR;
                end
            end

            ST_QR:
            begin
                if (r_reg[0])
                begin
                    rd_en          = 1'b1;
                    rd_addr        = TREE_W'(r_reg - PTR_W'(1));
                    pend_next      = 1'b1;
                    pend_side_next = SIDE_R;
                    r_next         = (r_reg - PTR_W'(1)) >> 1;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                l_next     = l_reg >> 1;
                state_next = ST_QL;
            end

            ST_QDONE:
            begin
                done_next = 1'b1;
                result_next.range_error = 1'b0;
                if (acc_l_vld_reg && acc_r_vld_reg)
                begin
                    result_next.max_height = acc_both.best;
                    result_next.max_index  = acc_both.where;
                end
                else if (acc_l_vld_reg)
                begin
                    result_next.max_height = acc_l_reg.best;
                    result_next.max_index  = acc_l_reg.where;
                end
                else
                begin
                    result_next.max_height = acc_r_reg.best;
                    result_next.max_index  = acc_r_reg.where;
                end
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            done_reg      <= 1'b0;
            acc_l_vld_reg <= 1'b0;
            acc_r_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            done_reg      <= done_next;
            acc_l_vld_reg <= acc_l_vld_next;
            acc_r_vld_reg <= acc_r_vld_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        node_reg      <= node_next;
        cur_reg       <= cur_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        acc_l_reg     <= acc_l_next;
        acc_r_reg     <= acc_r_next;
        pend_side_reg <= pend_side_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> rtl/rmq_checker.sv
module rmq_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rmq_pkg::rmq_cmd_t    cmd,
    input  logic                 busy,
    input  logic                 done,
    input  rmq_pkg::rmq_result_t result
);

    import rmq_pkg::*;

    logic take;
    logic q_bad;

    assign take  = start && !busy;
    assign q_bad = (cmd.index_low > cmd.index_high) ||
                   ({1'b0, cmd.index_high} >= (IDX_W+1)'(ENTRIES));

    // a range error result carries no height or position
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.range_error |-> result.max_height == '0 && result.max_index == '0)
        else $error("range error result with nonzero payload");

    // a write item gives no result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.opcode == OP_WRITE |=> !done)
        else $error("result strobe after write item");

    // a bad query range answers at once
    a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.opcode == OP_QUERY && q_bad |=> done && result.range_error && !busy)
        else $error("bad query range not answered next cycle");

    // a good query keeps the block busy and gives no result yet
    a_good_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take && cmd.opcode == OP_QUERY && !q_bad |=> busy && !done)
        else $error("valid query not in progress");

    // a result only follows an item in progress or just taken
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy) || $past(take))
        else $error("result strobe without an item");

endmodule

bind range_max_with_index_query_top rmq_checker u_rmq_checker (.*);

>>> dv/range_max_with_index_query_checker.sv
`timescale 1ns / 100ps

module range_max_with_index_query_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  rmq_pkg::rmq_cmd_t    cmd,
    input  logic                 done,
    input  rmq_pkg::rmq_result_t result,
    output int unsigned          fail_count,
    output int unsigned          pending_count
);

    import rmq_pkg::*;

    logic [HEIGHT_W-1:0] heights [ENTRIES];
    rmq_result_t         answers_due [$];

    initial
    begin
        fail_count    = 0;
        pending_count = 0;
        foreach (heights[i])
            heights[i] = '0;
    end

    // leftmost maximum over the closed range, scanned directly
    function automatic rmq_result_t range_max_lookup(rmq_cmd_t c);
        rmq_result_t r;
        r = '0;
        if (c.index_low > c.index_high || int'(c.index_high) >= ENTRIES)
        begin
            r.range_error = 1'b1;
        end
        else
        begin
            r.max_height = heights[c.index_low];
            r.max_index  = c.index_low;
            for (int i = int'(c.index_low) + 1; i <= int'(c.index_high); i++)
            begin
                if (heights[i] > r.max_height)
                begin
                    r.max_height = heights[i];
                    r.max_index  = IDX_W'(i);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        rmq_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (answers_due.size() == 0)
                begin
                    $error("result with no query outstanding: %p", result);
                    fail_count++;
                end
                else
                begin
                    want = answers_due.pop_front();
                    if (result.max_height !== want.max_height)
                    begin
                        $error("max_height: expected %0d, got %0d",
                               want.max_height, result.max_height);
                        fail_count++;
                    end
                    if (result.max_index !== want.max_index)
                    begin
                        $error("max_index: expected %0d, got %0d",
                               want.max_index, result.max_index);
                        fail_count++;
                    end
                    if (result.range_error !== want.range_error)
                    begin
                        $error("range_error: expected %0d, got %0d",
                               want.range_error, result.range_error);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                if (cmd.opcode == OP_WRITE)
                begin
                    if (int'(cmd.index_low) < ENTRIES)
                        heights[cmd.index_low] = cmd.height;
                end
                else
                begin
                    answers_due.push_back(range_max_lookup(cmd));
                end
            end
        end
        pending_count <= answers_due.size();
    end

endmodule

>>> dv/range_max_with_index_query_top_tb.sv
`timescale 1ns / 100ps

module range_max_with_index_query_top_tb;

    import rmq_pkg::*;

    // number of random items after the directed opening
    localparam int unsigned RANDOM_ITEMS = 1430;
    // cycles with no handshake before the run is abandoned
    localparam int unsigned STALL_LIMIT  = 2000;
    // covers the longest query or write still in progress at the end
    localparam int unsigned DRAIN_CYCLES = 40;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    rmq_cmd_t    cmd;
    logic        busy;
    logic        done;
    rmq_result_t result;

    int unsigned fail_count;
    int unsigned pending_count;
    int unsigned idle_cycles;

    // entries written so far; random queries with a proper range stay inside written runs
    bit          filled [ENTRIES];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    range_max_with_index_query_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    range_max_with_index_query_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .done          (done),
        .result        (result),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // watchdog: any accepted item or result restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("range_max_with_index_query_top_tb: errors");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // heights lean toward small values and the top value so ties are common
    function automatic logic [HEIGHT_W-1:0] rand_height();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 25)
            return HEIGHT_W'($urandom_range(0, 3));
        else if (sel < 35)
            return '1;
        return HEIGHT_W'($urandom());
    endfunction

    // index_high is ignored by a write, so it carries noise
    function automatic rmq_cmd_t write_cmd(int unsigned pos, logic [HEIGHT_W-1:0] h);
        rmq_cmd_t c;
        c.opcode     = OP_WRITE;
        c.index_low  = IDX_W'(pos);
        c.index_high = IDX_W'($urandom());
        c.height     = h;
        return c;
    endfunction

    // height is ignored by a query, so it carries noise
    function automatic rmq_cmd_t query_cmd(int unsigned lo, int unsigned hi);
        rmq_cmd_t c;
        c.opcode     = OP_QUERY;
        c.index_low  = IDX_W'(lo);
        c.index_high = IDX_W'(hi);
        c.height     = HEIGHT_W'($urandom());
        return c;
    endfunction

    // half the writes grow an existing run, the rest land anywhere
    function automatic rmq_cmd_t random_write();
        int unsigned pos;
        pos = $urandom_range(0, ENTRIES - 1);
        if ($urandom_range(0, 1) == 1)
            while (filled[pos] && pos < ENTRIES - 1)
                pos++;
        return write_cmd(pos, rand_height());
    endfunction

    // mostly short spans, some long ones, one in ten a reversed range
    function automatic rmq_cmd_t random_query();
        int unsigned lo;
        int unsigned hi;
        int unsigned span;
        int unsigned tries;
        if ($urandom_range(0, 9) == 0)
        begin
            lo = $urandom_range(1, ENTRIES - 1);
            hi = $urandom_range(0, lo - 1);
            return query_cmd(lo, hi);
        end
        lo    = $urandom_range(0, ENTRIES - 1);
        tries = 0;
        while (!filled[lo] && tries < ENTRIES)
        begin
            lo = (lo + 1) % ENTRIES;
            tries++;
        end
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, ENTRIES - 1)
                                           : $urandom_range(0, 15);
        hi = lo;
        while (hi - lo < span && hi < ENTRIES - 1 && filled[hi + 1])
            hi++;
        return query_cmd(lo, hi);
    endfunction

    // start stays high on return so back-to-back items need no re-raise
    task automatic issue(input rmq_cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (c.opcode == OP_WRITE)
            filled[c.index_low] = 1'b1;
    endtask

    initial
    begin
        int unsigned rand_sent;
        int unsigned burst_len;
        int unsigned gap;
        int unsigned sel;
        int unsigned base;
        int unsigned run;
        bit          paused;

        rst_n  = 1'b0;
        start  = 1'b0;
        cmd    = '0;
        paused = 1'b0;
        foreach (filled[i])
            filled[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both ends of the index range, top and zero heights
        issue(write_cmd(0, '1));
        issue(write_cmd(ENTRIES - 1, '0));
        issue(write_cmd(1, '0));
        issue(write_cmd(ENTRIES - 2, '1));
        issue(write_cmd(2, '1));
        // single-entry ranges at both ends
        issue(query_cmd(0, 0));
        issue(query_cmd(ENTRIES - 1, ENTRIES - 1));
        // tie between 0 and 2 must report the leftmost
        issue(query_cmd(0, 2));
        issue(query_cmd(1, 2));
        issue(query_cmd(ENTRIES - 2, ENTRIES - 1));
        // range whose only height is zero
        issue(query_cmd(1, 1));
        // low above high gives an error and zero fields
        issue(query_cmd(5, 4));
        issue(query_cmd(ENTRIES - 1, 0));
        issue(query_cmd(1, 0));
        // alternating bit patterns across the tree midpoint
        issue(write_cmd(ENTRIES / 2 - 1, 31'h2AAAAAAA));
        issue(write_cmd(ENTRIES / 2, 31'h55555555));
        issue(query_cmd(ENTRIES / 2 - 1, ENTRIES / 2));
        // overwrite lowers a stored maximum
        issue(write_cmd(0, 31'd3));
        issue(query_cmd(0, 1));
        issue(query_cmd(0, 2));

        // random part: bursts of items separated by random gaps
        rand_sent = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            burst_len = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
            for (int k = 0; k < burst_len; k++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 4)
                begin
                    // contiguous fill so later queries span many tree nodes
                    base = $urandom_range(0, ENTRIES - 1);
                    run  = $urandom_range(8, 64);
                    if (base + run > ENTRIES)
                        run = ENTRIES - base;
                    for (int j = 0; j < run; j++)
                        issue(write_cmd(base + j, rand_height()));
                    rand_sent += run;
                end
                else if (sel < 45)
                begin
                    issue(random_write());
                    rand_sent++;
                end
                else
                begin
                    issue(random_query());
                    rand_sent++;
                end
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (!paused && rand_sent >= RANDOM_ITEMS / 2)
            begin
                // hold off until every outstanding result is back
                paused = 1'b1;
                start <= 1'b0;
                @(posedge clk);
                while (pending_count != 0)
                    @(posedge clk);
                repeat (gap) @(posedge clk);
            end
            else if (gap != 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end

        // drain: the pending count is a registered copy of the checker's queue size
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("range_max_with_index_query_top_tb: clean");
        else
            $display("range_max_with_index_query_top_tb: errors");
        $finish;
    end

endmodule
